>>> rtl/ccc_pkg.sv
// Package: types, constants and calendar helpers for the calendar clock counter.
`timescale 1ns / 1ps

package ccc_pkg;

  localparam logic [11:0] YearReset  = 12'd1970;
  localparam logic [11:0] YearSetMin = 12'd1970;
  localparam logic [11:0] YearSetMax = 12'd2099;
  localparam logic [11:0] YearMax    = 12'd4095;
  localparam logic [11:0] Year1600   = 12'd1600;
  localparam logic [11:0] Year1900   = 12'd1900;
  localparam logic [11:0] Year2000   = 12'd2000;
  localparam logic [6:0]  Mod100Last = 7'd99;
  localparam logic [8:0]  Mod400Last = 9'd399;
  localparam logic [6:0]  Mod100Reset = 7'd70;
  localparam logic [8:0]  Mod400Reset = 9'd370;
  localparam logic [5:0]  SecLast    = 6'd59;
  localparam logic [5:0]  MinLast    = 6'd59;
  localparam logic [4:0]  HourLast   = 5'd23;
  localparam logic [7:0]  TpsReset   = 8'd8;

  localparam logic [3:0] MonthJan = 4'd1;
  localparam logic [3:0] MonthFeb = 4'd2;
  localparam logic [3:0] MonthMar = 4'd3;
  localparam logic [3:0] MonthApr = 4'd4;
  localparam logic [3:0] MonthMay = 4'd5;
  localparam logic [3:0] MonthJun = 4'd6;
  localparam logic [3:0] MonthJul = 4'd7;
  localparam logic [3:0] MonthAug = 4'd8;
  localparam logic [3:0] MonthSep = 4'd9;
  localparam logic [3:0] MonthOct = 4'd10;
  localparam logic [3:0] MonthNov = 4'd11;
  localparam logic [3:0] MonthDec = 4'd12;

  localparam logic CmdTick = 1'b0;
  localparam logic CmdSet  = 1'b1;

  localparam logic StatusOk      = 1'b0;
  localparam logic StatusRefused = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [11:0] set_year;
    logic [3:0]  set_month;
    logic [4:0]  set_day;
    logic [4:0]  set_hours;
    logic [5:0]  set_minutes;
    logic [5:0]  set_seconds;
  } in_beat_t;

  typedef struct packed {
    logic        status;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
  } out_beat_t;

  // Days in a month; zero for a month code outside January to December.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      MonthJan, MonthMar, MonthMay, MonthJul,
      MonthAug, MonthOct, MonthDec: len = 5'd31;
      MonthApr, MonthJun, MonthSep, MonthNov: len = 5'd30;
      MonthFeb: len = leap ? 5'd29 : 5'd28;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

>>> rtl/ccc_if.sv
// Interfaces: input, result and configuration channels of the calendar clock counter.
`timescale 1ns / 1ps

interface ccc_in_if;
  logic              valid;
  logic              ready;
  ccc_pkg::in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ccc_out_if;
  logic               valid;
  logic               ready;
  ccc_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ccc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/calendar_clock_counter_core.sv
// Top level: Gregorian calendar clock with prescaler, range-checked set and skid output.
//
// channel | dir | beat contents
// --------+-----+-----------------------------------------------------------
// in_i    | in  | cmd (tick or set) and the date and time to load on set
// out_o   | out | status and the date and time after the item
// cfg_i   | in  | ticks_per_second, always ready
//
// One item per cycle while in_i is ready: the carry chain, leap test and set check
// sit between the state registers and the result register, so the state update is
// combinational. Reset brings the clock to 1970-01-01 00:00:00, prescaler 0, eight
// ticks a second. A result register plus one skid entry hold results while out_o
// stalls; in_i drops ready only when both are full.
`timescale 1ns / 1ps

module calendar_clock_counter_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  ccc_in_if.sink    in_i,
  ccc_out_if.source out_o,
  ccc_cfg_if.sink   cfg_i
);
  import ccc_pkg::*;

  logic [7:0]  tps_q;
  logic [7:0]  tick_q, tick_d;
  logic [5:0]  sec_q, sec_d;
  logic [5:0]  min_q, min_d;
  logic [4:0]  hour_q, hour_d;
  logic [4:0]  day_q, day_d;
  logic [3:0]  mon_q, mon_d;
  logic [11:0] year_q, year_d;
  logic [6:0]  mod100_q, mod100_d;
  logic [8:0]  mod400_q, mod400_d;

  out_beat_t out_q, skid_q, res;
  logic      out_valid_q, skid_valid_q;

  logic       push, pop;
  logic [8:0] tick_inc;
  logic [7:0] limit;
  logic       sec_due, cur_leap;
  logic       sec_wrap, min_wrap, hour_wrap, day_wrap, mon_wrap;
  logic       set_leap, set_ok;
  logic [11:0] set_off100, set_off400;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !skid_valid_q;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  assign push = in_i.valid && !skid_valid_q;
  assign pop  = out_valid_q && out_o.ready;

  // Leap year from the running year residues.
  assign cur_leap = (mod400_q == 9'd0) || ((mod100_q != 7'd0) && (year_q[1:0] == 2'd0));

  assign tick_inc = {1'b0, tick_q} + 9'd1;
  assign limit    = (tps_q == 8'd0) ? 8'd1 : tps_q;
  assign sec_due  = tick_inc >= {1'b0, limit};

  assign sec_wrap  = sec_q >= SecLast;
  assign min_wrap  = min_q >= MinLast;
  assign hour_wrap = hour_q >= HourLast;
  assign day_wrap  = day_q >= month_len(mon_q, cur_leap);
  assign mon_wrap  = mon_q >= MonthDec;

  // Within the settable range a year divisible by four is a leap year.
  assign set_leap = (in_i.data.set_year[1:0] == 2'd0);
  assign set_ok   = (in_i.data.set_year >= YearSetMin) && (in_i.data.set_year <= YearSetMax)
                 && (in_i.data.set_month >= MonthJan) && (in_i.data.set_month <= MonthDec)
                 && (in_i.data.set_day != 5'd0)
                 && (in_i.data.set_day <= month_len(in_i.data.set_month, set_leap))
                 && (in_i.data.set_hours <= HourLast)
                 && (in_i.data.set_minutes <= MinLast)
                 && (in_i.data.set_seconds <= SecLast);

  assign set_off100 = in_i.data.set_year -
                      ((in_i.data.set_year >= Year2000) ? Year2000 : Year1900);
  assign set_off400 = in_i.data.set_year -
                      ((in_i.data.set_year >= Year2000) ? Year2000 : Year1600);

  always_comb begin
    tick_d   = tick_q;
    sec_d    = sec_q;
    min_d    = min_q;
    hour_d   = hour_q;
    day_d    = day_q;
    mon_d    = mon_q;
    year_d   = year_q;
    mod100_d = mod100_q;
    mod400_d = mod400_q;
    res.status = StatusOk;
    if (in_i.data.cmd == CmdTick) begin
      tick_d = sec_due ? 8'd0 : tick_inc[7:0];
      if (sec_due) begin
        sec_d = sec_wrap ? 6'd0 : sec_q + 6'd1;
        if (sec_wrap) begin
          min_d = min_wrap ? 6'd0 : min_q + 6'd1;
          if (min_wrap) begin
            hour_d = hour_wrap ? 5'd0 : hour_q + 5'd1;
            if (hour_wrap) begin
              day_d = day_wrap ? 5'd1 : day_q + 5'd1;
              if (day_wrap) begin
                mon_d = mon_wrap ? MonthJan : mon_q + 4'd1;
                // Hold the year at its ceiling; month and day still wrap.
                if (mon_wrap && (year_q != YearMax)) begin
                  year_d   = year_q + 12'd1;
                  mod100_d = (mod100_q == Mod100Last) ? 7'd0 : mod100_q + 7'd1;
                  mod400_d = (mod400_q == Mod400Last) ? 9'd0 : mod400_q + 9'd1;
                end
              end
            end
          end
        end
      end
    end else begin
      if (set_ok) begin
        sec_d    = in_i.data.set_seconds;
        min_d    = in_i.data.set_minutes;
        hour_d   = in_i.data.set_hours;
        day_d    = in_i.data.set_day;
        mon_d    = in_i.data.set_month;
        year_d   = in_i.data.set_year;
        mod100_d = set_off100[6:0];
        mod400_d = set_off400[8:0];
      end else begin
        res.status = StatusRefused;
      end
    end
    res.year    = year_d;
    res.month   = mon_d;
    res.day     = day_d;
    res.hours   = hour_d;
    res.minutes = min_d;
    res.seconds = sec_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q    <= TpsReset;
      tick_q   <= 8'd0;
      sec_q    <= 6'd0;
      min_q    <= 6'd0;
      hour_q   <= 5'd0;
      day_q    <= 5'd1;
      mon_q    <= MonthJan;
      year_q   <= YearReset;
      mod100_q <= Mod100Reset;
      mod400_q <= Mod400Reset;
    end else begin
      if (cfg_i.valid) begin
        tps_q <= cfg_i.data;
      end
      if (push) begin
        tick_q   <= tick_d;
        sec_q    <= sec_d;
        min_q    <= min_d;
        hour_q   <= hour_d;
        day_q    <= day_d;
        mon_q    <= mon_d;
        year_q   <= year_d;
        mod100_q <= mod100_d;
        mod400_q <= mod400_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        // Advance the parked beat once the sink takes the current one.
        if (pop) begin
          skid_valid_q <= 1'b0;
        end
      end else if (push) begin
        if (out_valid_q && !pop) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

endmodule

>>> test/ccc_checker.sv
// Checker: predicts calendar clock results from accepted beats and compares them.
`timescale 1ns / 1ps

module ccc_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  ccc_in_if           in_mon,
  ccc_out_if          out_mon,
  ccc_cfg_if          cfg_mon,
  output int unsigned errors_o,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned refused_o,
  output int unsigned rollovers_o
);
  import ccc_pkg::*;

  localparam int unsigned MaxPrinted = 50;

  logic [7:0]  prescale;
  logic [7:0]  tick_cnt;
  logic [11:0] now_year;
  logic [3:0]  now_month;
  logic [4:0]  now_day;
  logic [4:0]  now_hours;
  logic [5:0]  now_minutes;
  logic [5:0]  now_seconds;
  out_beat_t   expected_dates[$];

  task automatic flag_mismatch(input string msg);
    if (errors_o < MaxPrinted) begin
      $display("%0t: mismatch on result %0d: %s", $time, checked_o, msg);
    end
    errors_o++;
  endtask

  task automatic check_field(input string name, input logic [11:0] got,
                             input logic [11:0] want);
    if (got !== want) begin
      flag_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    end
  endtask

  function automatic logic [4:0] days_in(input logic [11:0] y, input logic [3:0] m);
    logic leap;
    leap = (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    case (m)
      MonthApr, MonthJun, MonthSep, MonthNov: return 5'd30;
      MonthFeb: return leap ? 5'd29 : 5'd28;
      MonthJan, MonthMar, MonthMay, MonthJul,
      MonthAug, MonthOct, MonthDec: return 5'd31;
      default: return 5'd0;
    endcase
  endfunction

  // Apply one accepted input beat to the predicted clock and return its result.
  function automatic out_beat_t calendar_step(input in_beat_t beat);
    out_beat_t   res;
    int unsigned limit;
    logic        in_range;
    res.status = StatusOk;
    if (beat.cmd == CmdTick) begin
      limit = (prescale == 8'd0) ? 1 : prescale;
      if (tick_cnt + 1 >= limit) begin
        tick_cnt = 8'd0;
        // carry the second up through the calendar
        if (now_seconds < SecLast) begin
          now_seconds++;
        end else begin
          now_seconds = 6'd0;
          if (now_minutes < MinLast) begin
            now_minutes++;
          end else begin
            now_minutes = 6'd0;
            if (now_hours < HourLast) begin
              now_hours++;
            end else begin
              now_hours = 5'd0;
              rollovers_o++;
              if (now_day < days_in(now_year, now_month)) begin
                now_day++;
              end else begin
                now_day = 5'd1;
                if (now_month < MonthDec) begin
                  now_month++;
                end else begin
                  now_month = MonthJan;
                  if (now_year < YearMax) now_year++;
                end
              end
            end
          end
        end
      end else begin
        tick_cnt = tick_cnt + 8'd1;
      end
    end else begin
      in_range = beat.set_year >= YearSetMin && beat.set_year <= YearSetMax &&
                 beat.set_month >= MonthJan && beat.set_month <= MonthDec &&
                 beat.set_day >= 5'd1 &&
                 beat.set_day <= days_in(beat.set_year, beat.set_month) &&
                 beat.set_hours <= HourLast && beat.set_minutes <= MinLast &&
                 beat.set_seconds <= SecLast;
      if (in_range) begin
        // the prescaler count is left alone by a set
        now_year    = beat.set_year;
        now_month   = beat.set_month;
        now_day     = beat.set_day;
        now_hours   = beat.set_hours;
        now_minutes = beat.set_minutes;
        now_seconds = beat.set_seconds;
      end else begin
        res.status = StatusRefused;
        refused_o++;
      end
    end
    res.year    = now_year;
    res.month   = now_month;
    res.day     = now_day;
    res.hours   = now_hours;
    res.minutes = now_minutes;
    res.seconds = now_seconds;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t want;
    if (!rst_ni) begin
      prescale    = TpsReset;
      tick_cnt    = 8'd0;
      now_year    = YearReset;
      now_month   = MonthJan;
      now_day     = 5'd1;
      now_hours   = 5'd0;
      now_minutes = 6'd0;
      now_seconds = 6'd0;
      expected_dates.delete();
      errors_o    = 0;
      checked_o   = 0;
      refused_o   = 0;
      rollovers_o = 0;
      pending_o   <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) prescale = cfg_mon.data;
      if (in_mon.valid && in_mon.ready) expected_dates.push_back(calendar_step(in_mon.data));
      if (out_mon.valid && out_mon.ready) begin
        if (expected_dates.size() == 0) begin
          flag_mismatch("result beat with nothing expected");
        end else begin
          want = expected_dates.pop_front();
          check_field("status", out_mon.data.status, want.status);
          check_field("year", out_mon.data.year, want.year);
          check_field("month", out_mon.data.month, want.month);
          check_field("day", out_mon.data.day, want.day);
          check_field("hours", out_mon.data.hours, want.hours);
          check_field("minutes", out_mon.data.minutes, want.minutes);
          check_field("seconds", out_mon.data.seconds, want.seconds);
        end
        checked_o++;
      end
      pending_o <= expected_dates.size();
    end
  end

endmodule

>>> test/tb.sv
// Testbench top: drives ticks, sets and prescale writes into the calendar clock core.
`timescale 1ns / 1ps

module tb;
  import ccc_pkg::*;

  localparam int          NumPhases   = 8;
  localparam int          PhaseItems  = 100;
  localparam int          HoldLen     = 60;
  localparam int          TimeoutNs   = 2_000_000;
  localparam logic [7:0]  PrescalePlan [NumPhases] = '{8'd1, 8'd1, 8'd255, 8'd0,
                                                       8'd200, 8'd3, 8'd1, 8'd2};

  logic clk = 1'b0;
  logic rst_n;

  ccc_in_if  in_if ();
  ccc_out_if out_if ();
  ccc_cfg_if cfg_if ();

  int unsigned errors;
  int unsigned pending;
  int unsigned checked;
  int unsigned refused;
  int unsigned rollovers;

  int unsigned items_sent;
  int          send_idle_pct;
  int          recv_idle_pct;
  logic        long_hold;
  int          hold_count = 0;

  always #5 clk = ~clk;

  calendar_clock_counter_core i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  ccc_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_mon      (in_if),
    .out_mon     (out_if),
    .cfg_mon     (cfg_if),
    .errors_o    (errors),
    .pending_o   (pending),
    .checked_o   (checked),
    .refused_o   (refused),
    .rollovers_o (rollovers)
  );

  // Result side: random stalls, plus one long hold-off counted here.
  always @(posedge clk) begin
    if (long_hold && hold_count < HoldLen) begin
      hold_count   <= hold_count + 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  function automatic in_beat_t set_beat(input int y, input int mo, input int d,
                                        input int h, input int mi, input int s);
    in_beat_t b;
    b.cmd         = CmdSet;
    b.set_year    = 12'(y);
    b.set_month   = 4'(mo);
    b.set_day     = 5'(d);
    b.set_hours   = 5'(h);
    b.set_minutes = 6'(mi);
    b.set_seconds = 6'(s);
    return b;
  endfunction

  function automatic in_beat_t random_bits(input logic cmd);
    logic [63:0] r;
    in_beat_t    b;
    r     = {$urandom, $urandom};
    b     = r[$bits(in_beat_t)-1:0];
    b.cmd = cmd;
    return b;
  endfunction

  // Mostly valid set close to a midnight, month end or year end.
  function automatic in_beat_t edge_set();
    int y, mo, d, h, mi, s;
    case ($urandom_range(0, 4))
      0: y = YearSetMin;
      1: y = YearSetMax;
      2: y = 1972 + 4 * $urandom_range(0, 31);
      default: y = $urandom_range(YearSetMin, YearSetMax);
    endcase
    mo = ($urandom_range(0, 3) == 0) ? MonthFeb : $urandom_range(MonthJan, MonthDec);
    d  = ($urandom_range(0, 9) < 7) ? $urandom_range(28, 31) : $urandom_range(1, 31);
    h  = ($urandom_range(0, 3) != 0) ? HourLast : $urandom_range(0, HourLast);
    mi = ($urandom_range(0, 3) != 0) ? MinLast : $urandom_range(0, MinLast);
    s  = ($urandom_range(0, 3) != 0) ? $urandom_range(50, SecLast) : $urandom_range(0, SecLast);
    return set_beat(y, mo, d, h, mi, s);
  endfunction

  // Valid-looking set with at least one field pushed out of range.
  function automatic in_beat_t broken_set();
    in_beat_t b;
    b = edge_set();
    case ($urandom_range(0, 5))
      0: b.set_year = $urandom_range(0, 1) ? 12'($urandom_range(0, YearSetMin - 1))
                                           : 12'($urandom_range(YearSetMax + 1, YearMax));
      1: b.set_month = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(13, 15));
      2: begin
        if ($urandom_range(0, 1)) begin
          b.set_day = 5'd0;
        end else begin
          b.set_month = MonthFeb;
          b.set_day   = 5'($urandom_range(30, 31));
        end
      end
      3: b.set_hours = 5'($urandom_range(24, 31));
      4: b.set_minutes = 6'($urandom_range(60, 63));
      default: b.set_seconds = 6'($urandom_range(60, 63));
    endcase
    return b;
  endfunction

  task automatic send_beat(input in_beat_t b);
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_prescale(input logic [7:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    #(TimeoutNs);
    $display("calendar_clock_counter_core test failed");
    $finish;
  end

  initial begin
    int unsigned start;
    int          pick;
    int          burst;
    logic        paused;
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.data    = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.data   = '0;
    items_sent    = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    long_hold     = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset prescale: the eighth tick adds the first second
    repeat (8) send_beat(random_bits(CmdTick));
    wait_drained();
    write_prescale(8'd1);
    send_beat(set_beat(YearSetMax, MonthDec, 31, HourLast, MinLast, SecLast));
    send_beat(random_bits(CmdTick));
    send_beat(set_beat(2000, MonthFeb, 29, HourLast, MinLast, SecLast));
    send_beat(random_bits(CmdTick));
    send_beat(set_beat(YearSetMin - 1, MonthJun, 15, 12, 30, 30));
    send_beat(set_beat(YearSetMax + 1, MonthJan, 1, 0, 0, 0));
    send_beat(set_beat(2020, 0, 10, 10, 10, 10));
    send_beat(set_beat(2020, 13, 10, 10, 10, 10));
    send_beat(set_beat(2020, MonthMay, 0, 10, 10, 10));
    send_beat(set_beat(2021, MonthApr, 31, 10, 10, 10));
    send_beat(set_beat(2001, MonthFeb, 29, 10, 10, 10));
    send_beat(set_beat(2020, MonthMay, 5, HourLast + 1, 10, 10));
    send_beat(set_beat(2020, MonthMay, 5, 10, MinLast + 1, 10));
    send_beat(set_beat(2020, MonthMay, 5, 10, 10, SecLast + 1));
    send_beat(set_beat(YearMax, 15, 31, 31, 63, 63));
    send_beat(set_beat(YearSetMin, MonthJan, 1, 0, 0, 0));

    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      repeat (3) @(posedge clk);
      write_prescale(PrescalePlan[p]);
      send_idle_pct = (p % 4 == 1) ? 53 : (p % 4 == 3) ? 20 : 0;
      recv_idle_pct <= (p % 4 == 2) ? 53 : (p % 4 == 3) ? 20 : 0;
      // hold results back long enough for the core to stall its input
      if (p == 4) long_hold <= 1'b1;
      paused = 1'b0;
      start  = items_sent;
      while (items_sent - start < PhaseItems) begin
        if (p == 5 && !paused && items_sent - start >= PhaseItems / 2) begin
          wait_drained();
          paused = 1'b1;
        end
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
          send_beat(edge_set());
          burst = $urandom_range(1, 12);
          repeat (burst) send_beat(random_bits(CmdTick));
        end else if (pick < 80) begin
          send_beat(random_bits(CmdTick));
        end else if (pick < 92) begin
          send_beat(broken_set());
        end else begin
          send_beat(random_bits(CmdSet));
        end
      end
    end

    wait_drained();
    repeat (5) @(posedge clk);
    $display("Sent %0d beats across %0d prescale settings, with idle, stall and hold mixes.",
             items_sent, NumPhases + 1);
    $display("Checked %0d results: %0d sets refused, %0d day rollovers.",
             checked, refused, rollovers);
    if (errors == 0) begin
      $display("calendar_clock_counter_core test passed");
    end else begin
      $display("calendar_clock_counter_core test failed");
    end
    $finish;
  end

endmodule
